### src/tfe_pkg.sv
package tfe_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 34;
  localparam int HDR_IDX_W = 4;
  localparam int HDR_LEN   = 10;
  localparam int SIZE_AT   = 6;
  localparam int ID_END    = 4;
  localparam int SIZE_END  = 8;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_FRAME   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } tfe_phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } tfe_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first;
    logic              end_of_stream;
  } tfe_item_t;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] out_byte;
    tfe_kind_t         kind;
    logic              last;
  } tfe_result_t;

  typedef struct packed {
    tfe_phase_t           phase;
    logic [POS_W-1:0]     byte_pos;
    logic [POS_W-1:0]     tag_end;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [WORD_W-1:0]    id_shift;
    logic [WORD_W-1:0]    size_shift;
    logic [WORD_W-1:0]    payload_left;
    logic                 matched;
  } tfe_state_t;

  localparam tfe_state_t ST_RESTART = '{
    phase:        PH_TAG,
    byte_pos:     '0,
    tag_end:      '0,
    hdr_idx:      '0,
    id_shift:     '0,
    size_shift:   '0,
    payload_left: '0,
    matched:      1'b0
  };

endpackage

### src/tfe_in_if.sv
interface tfe_in_if;
  import tfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first;
  logic              end_of_stream;

  modport source (output valid, output data_byte, output first, output end_of_stream,
                  input ready);
  modport sink   (input valid, input data_byte, input first, input end_of_stream,
                  output ready);
endinterface

### src/tfe_out_if.sv
interface tfe_out_if;
  import tfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  tfe_kind_t         kind;
  logic              last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

### src/tfe_step.sv
module tfe_step (
  input  tfe_pkg::tfe_state_t              st_i,
  input  tfe_pkg::tfe_item_t               item_i,
  input  logic [tfe_pkg::WORD_W-1:0]       wanted_id_i,
  output tfe_pkg::tfe_state_t              st_o,
  output tfe_pkg::tfe_result_t             res_o
);
  import tfe_pkg::*;

  tfe_state_t  s;
  tfe_result_t r;

  always_comb begin
    s = st_i;
    r = '{vld: 1'b0, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b0};
    if (item_i.first) begin
      s = ST_RESTART;
    end
    unique case (s.phase)
      PH_TAG: begin
        if (s.hdr_idx >= HDR_IDX_W'(SIZE_AT)) begin
          s.size_shift = {s.size_shift[WORD_W-BYTE_W-1:0], item_i.data_byte};
        end
        s.hdr_idx  = s.hdr_idx + HDR_IDX_W'(1);
        s.byte_pos = s.byte_pos + POS_W'(1);
        if (s.hdr_idx >= HDR_IDX_W'(HDR_LEN)) begin
          s.hdr_idx = '0;
          s.tag_end = POS_W'(s.size_shift) + POS_W'(HDR_LEN);
          if (s.byte_pos >= s.tag_end) begin
            s.phase = PH_DONE;
            r = '{vld: 1'b1, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b1};
          end else begin
            s.phase = PH_FRAME;
          end
        end
      end
      PH_FRAME: begin
        if (s.hdr_idx < HDR_IDX_W'(ID_END)) begin
          s.id_shift = {s.id_shift[WORD_W-BYTE_W-1:0], item_i.data_byte};
        end else if (s.hdr_idx < HDR_IDX_W'(SIZE_END)) begin
          s.size_shift = {s.size_shift[WORD_W-BYTE_W-1:0], item_i.data_byte};
        end
        s.hdr_idx  = s.hdr_idx + HDR_IDX_W'(1);
        s.byte_pos = s.byte_pos + POS_W'(1);
        if (s.hdr_idx >= HDR_IDX_W'(HDR_LEN)) begin
          s.hdr_idx = '0;
          if (s.id_shift == wanted_id_i) begin
            if (s.size_shift == '0) begin
              s.phase = PH_DONE;
              r = '{vld: 1'b1, out_byte: '0, kind: KIND_EMPTY, last: 1'b1};
            end else begin
              s.payload_left = s.size_shift;
              s.matched      = 1'b1;
              s.phase        = PH_PAYLOAD;
            end
          end else if (s.id_shift[WORD_W-1 -: BYTE_W] == '0) begin
            s.phase = PH_DONE;
            r = '{vld: 1'b1, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b1};
          end else if (s.size_shift == '0) begin
            if (s.byte_pos >= s.tag_end) begin
              s.phase = PH_DONE;
              r = '{vld: 1'b1, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b1};
            end else begin
              s.phase = PH_FRAME;
            end
          end else begin
            s.payload_left = s.size_shift;
            s.matched      = 1'b0;
            s.phase        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        s.byte_pos     = s.byte_pos + POS_W'(1);
        s.payload_left = s.payload_left - WORD_W'(1);
        if (s.matched) begin
          r = '{vld: 1'b1, out_byte: item_i.data_byte, kind: KIND_PAYLOAD,
                last: (s.payload_left == '0)};
          if (s.payload_left == '0) begin
            s.phase = PH_DONE;
          end
        end else if (s.payload_left == '0) begin
          if (s.byte_pos >= s.tag_end) begin
            s.phase = PH_DONE;
            r = '{vld: 1'b1, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b1};
          end else begin
            s.phase = PH_FRAME;
          end
        end
      end
      PH_DONE: begin
      end
    endcase
    if (item_i.end_of_stream && s.phase != PH_DONE) begin
      if (r.vld) begin
        r.last = 1'b1;
      end else if (s.phase == PH_PAYLOAD && s.matched) begin
        r = '{vld: 1'b1, out_byte: '0, kind: KIND_EMPTY, last: 1'b1};
      end else begin
        r = '{vld: 1'b1, out_byte: '0, kind: KIND_NOT_FOUND, last: 1'b1};
      end
      s.phase = PH_DONE;
    end
    st_o  = s;
    res_o = r;
  end

endmodule

### src/tag_frame_extractor_core.sv
// Frame extractor for tagged audio streams: feed the file one byte per request, the first
// byte flagged with first and the final byte with end_of_stream. The block parses the tag
// header and frame headers on the fly and returns the payload bytes of the first frame whose
// id equals cfg_wdata (last set on the final byte), or a single found-empty or not-found
// result. It takes one byte every clock while the result register is not stalled; a taken byte
// sits in the input register while the combinational parse step runs, and its result, if any,
// is loaded into the result register once that register can advance.
// Write the frame id only while no search is in flight.
module tag_frame_extractor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  tfe_in_if.sink                      in_req,
  tfe_out_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [tfe_pkg::WORD_W-1:0]  cfg_wdata
);
  import tfe_pkg::*;

  logic [WORD_W-1:0] wanted_id_r;
  logic              s1_vld_r;
  tfe_item_t         s1_item_r;
  tfe_state_t        st_r;
  tfe_state_t        st_nxt;
  tfe_result_t       step_res;
  logic              out_vld_r;
  tfe_result_t       out_res_r;
  logic              out_adv;
  logic              s1_take;
  logic              in_take;

  assign out_adv      = !out_vld_r || out_res.ready;
  assign s1_take      = s1_vld_r && out_adv;
  assign in_req.ready = !s1_vld_r || out_adv;
  assign in_take      = in_req.valid && in_req.ready;

  tfe_step u_step (
    .st_i        (st_r),
    .item_i      (s1_item_r),
    .wanted_id_i (wanted_id_r),
    .st_o        (st_nxt),
    .res_o       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_id_r <= '0;
    end else if (cfg_we) begin
      wanted_id_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_take) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{data_byte: in_req.data_byte, first: in_req.first,
                     end_of_stream: in_req.end_of_stream};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESTART;
    end else if (s1_take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_take && step_res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && out_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_res.valid    = out_vld_r;
  assign out_res.out_byte = out_res_r.out_byte;
  assign out_res.kind     = out_res_r.kind;
  assign out_res.last     = out_res_r.last;

endmodule

### src/tfe_checker.sv
module tfe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tfe_pkg::BYTE_W-1:0]  out_byte,
  input tfe_pkg::tfe_kind_t          kind,
  input logic                        last
);
  import tfe_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(last))
  else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_PAYLOAD |-> last)
  else $error("empty or not-found result without last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_PAYLOAD |-> out_byte == '0)
  else $error("nonzero byte on status result");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
  else $error("input stalled with empty result register");

endmodule

bind tag_frame_extractor_core tfe_checker u_tfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_byte  (out_res.out_byte),
  .kind      (out_res.kind),
  .last      (out_res.last)
);
